// ===== hdl/key1_blowfish_cipher_macros.svh =====
// Assertion macros shared by the cipher RTL.
`ifndef KEY1_BLOWFISH_CIPHER_MACROS_SVH
`define KEY1_BLOWFISH_CIPHER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kbc_pkg.sv =====
// Types, constants and helpers for the cipher engine.
package kbc_pkg;

  localparam logic [10:0] TBL_WORDS = 11'h412;
  localparam logic [10:0] P_WORDS   = 11'h012;
  localparam logic [10:0] BOX_BASE  = 11'h012;
  localparam logic [10:0] LAST_PAIR = 11'h410;
  localparam logic [4:0]  ROUNDS    = 5'd16;
  localparam logic [4:0]  P_LAST    = 5'h11;
  localparam int unsigned P_DEPTH   = 18;
  localparam int unsigned NUM_BOXES = 4;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ENC   = 2'd1,
    KIND_DEC   = 2'd2,
    KIND_INIT  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN,
    ST_KI_CHECK,
    ST_KI_LAUNCH1,
    ST_KI_E1,
    ST_KI_LAUNCH2,
    ST_KI_E2,
    ST_KI_XOR,
    ST_KI_LAUNCHC,
    ST_KI_EC,
    ST_KI_WHI,
    ST_KI_WLO,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] table_index;
    logic [31:0] table_word;
    logic [63:0] block_in;
    logic [1:0]  key_level;
  } req_t;

  typedef struct packed {
    logic [63:0] block_out;
    logic [1:0]  done_kind;
  } rsp_t;

  // one word into the key table
  typedef struct packed {
    logic        en;
    logic [10:0] idx;
    logic [31:0] data;
  } tbl_wr_t;

  // key code mix into the round words
  typedef struct packed {
    logic        en;
    logic [31:0] k0;
    logic [31:0] k1;
  } key_mix_t;

  // engine -> store read requests
  typedef struct packed {
    logic [4:0]      p_idx;
    logic            wht_dec;
    logic [3:0][7:0] box_addr;
  } eng_rd_t;

  // store -> engine read data
  typedef struct packed {
    logic [31:0]      p_word;
    logic [31:0]      wht_hi;
    logic [31:0]      wht_lo;
    logic [3:0][31:0] box_data;
  } st_rd_t;

  function automatic logic [31:0] bswap32(input logic [31:0] d);
    return {d[7:0], d[15:8], d[23:16], d[31:24]};
  endfunction

endpackage

// ===== hdl/kbc_box_ram.sv =====
// One 256 x 32 box memory, one write port, one registered read port.
module kbc_box_ram
  import kbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [7:0]  waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [7:0]  raddr_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [256];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/kbc_key_store.sv =====
// Key table: 18 round words in flops and four box memories.
module kbc_key_store
  import kbc_pkg::*;
(
  input  logic     clk_i,
  input  tbl_wr_t  wr_i,
  input  key_mix_t mix_i,
  input  eng_rd_t  rd_i,
  output st_rd_t   rd_o
);

  logic [31:0] p_q [P_DEPTH];
  logic        in_p;
  logic        in_box;
  logic [10:0] off;

  assign in_p   = wr_i.idx < P_WORDS;
  assign in_box = !in_p && (wr_i.idx < TBL_WORDS);
  assign off    = wr_i.idx - BOX_BASE;

  always_ff @(posedge clk_i) begin
    if (mix_i.en) begin
      for (int i = 0; i < P_DEPTH; i++) begin
        p_q[i] <= p_q[i] ^ bswap32((i % 2 == 0) ? mix_i.k0 : mix_i.k1);
      end
    end else if (wr_i.en && in_p) begin
      p_q[wr_i.idx[4:0]] <= wr_i.data;
    end
  end

  for (genvar b = 0; b < NUM_BOXES; b++) begin : g_box
    logic we;
    assign we = wr_i.en && in_box && (off[9:8] == 2'(b));
    kbc_box_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (off[7:0]),
      .wdata_i (wr_i.data),
      .raddr_i (rd_i.box_addr[b]),
      .rdata_o (rd_o.box_data[b])
    );
  end

  assign rd_o.p_word = p_q[rd_i.p_idx];
  assign rd_o.wht_hi = rd_i.wht_dec ? p_q[0] : p_q[17];
  assign rd_o.wht_lo = rd_i.wht_dec ? p_q[1] : p_q[16];

endmodule

// ===== hdl/kbc_round_engine.sv =====
// Round sequencer: one round per cycle against the box memories.
module kbc_round_engine
  import kbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        dec_i,
  input  logic [63:0] blk_i,
  input  st_rd_t      rd_i,
  output eng_rd_t     rd_o,
  output logic        done_o,
  output logic [63:0] blk_o
);

`include "key1_blowfish_cipher_macros.svh"

  logic        busy_q, busy_d;
  logic [4:0]  r_q, r_d;
  logic        dec_q, dec_d;
  logic [31:0] y_q, y_d;
  logic [31:0] yp_q, yp_d;
  logic [31:0] f;
  logic [31:0] x_cur;
  logic [31:0] z;
  logic [4:0]  rnd;
  logic        cur_dec;
  logic        last;

  assign f       = ((rd_i.box_data[0] + rd_i.box_data[1]) ^ rd_i.box_data[2])
                   + rd_i.box_data[3];
  assign cur_dec = start_i ? dec_i : dec_q;
  assign rnd     = start_i ? 5'd0 : r_q;
  // first round takes x from the block, later ones from the box data just read
  assign x_cur   = start_i ? blk_i[63:32] : (yp_q ^ f);
  assign z       = rd_i.p_word ^ x_cur;
  assign last    = busy_q && (r_q == ROUNDS);

  assign rd_o.p_idx    = cur_dec ? (P_LAST - rnd) : rnd;
  assign rd_o.wht_dec  = dec_q;
  assign rd_o.box_addr = {z[7:0], z[15:8], z[23:16], z[31:24]};

  assign done_o = last;
  assign blk_o  = {y_q ^ rd_i.wht_hi, x_cur ^ rd_i.wht_lo};

  always_comb begin
    busy_d = busy_q;
    r_d    = r_q;
    dec_d  = dec_q;
    y_d    = y_q;
    yp_d   = yp_q;
    if (start_i) begin
      busy_d = 1'b1;
      r_d    = 5'd1;
      dec_d  = dec_i;
      y_d    = z;
      yp_d   = blk_i[31:0];
    end else if (busy_q) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        r_d  = r_q + 5'd1;
        y_d  = z;
        yp_d = y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      r_q    <= '0;
      dec_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      r_q    <= r_d;
      dec_q  <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q  <= y_d;
    yp_q <= yp_d;
  end

  `KBC_ASSERT_IMP(a_start_when_free, start_i, !busy_q, "engine started while busy")
  `KBC_ASSERT_NXT(a_done_frees, done_o, !busy_q, "engine still busy after last round")
  `KBC_ASSERT_NXT(a_round_steps, busy_q && !done_o, busy_q && (r_q == $past(r_q) + 5'd1),
                  "round counter skipped")

endmodule

// ===== hdl/key1_blowfish_cipher.sv =====
// Top level: request sequencing, key init control and result register.
//
// 64-bit Blowfish-style cipher with the key table held on chip (18 round
// words in flops, four 256-word box memories). Encrypt and decrypt run in
// the round engine at one round per cycle, since each round's box reads
// come back in the cycle after the address is issued and feed the next
// round's address directly; the result then passes through the result
// register. Key init at level L runs, per level step, 521 chained
// encryptions for the table refill, two key code encryptions and a mix
// step; level 0 runs no step. One request is in work at a time; the
// result register lets the next request be taken while a result beat
// waits. The host must load the original table before each key init; the
// host must write game_code only while idle, which the block itself does
// not enforce.
module key1_blowfish_cipher
  import kbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

`include "key1_blowfish_cipher_macros.svh"

  state_e      state_q, state_d;
  logic [31:0] game_code_q, game_code_d;
  logic [31:0] k0_q, k0_d, k1_q, k1_d, k2_q, k2_d;
  logic [63:0] chain_q, chain_d;
  logic [10:0] idx_q, idx_d;
  logic [1:0]  app_q, app_d;
  logic [1:0]  level_q, level_d;
  kind_e       kind_q, kind_d;
  logic [63:0] res_q, res_d;
  logic        out_valid_q, out_valid_d;
  rsp_t        out_q, out_d;

  logic        in_fire;
  logic        out_free;
  logic        load_out;
  kind_e       in_kind;

  logic        eng_start;
  logic        eng_dec;
  logic [63:0] eng_blk;
  logic        eng_done;
  logic [63:0] eng_out;
  eng_rd_t     eng_rd;
  st_rd_t      st_rd;
  tbl_wr_t     tbl_wr;
  key_mix_t    key_mix;

  assign in_kind     = kind_e'(in_data_i.req_type);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_out    = (state_q == ST_FINISH) && out_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            KIND_WRITE:         state_d = ST_FINISH;
            KIND_ENC, KIND_DEC: state_d = ST_RUN;
            KIND_INIT:          state_d = ST_KI_CHECK;
            default:            state_d = ST_FINISH;
          endcase
        end
      end
      ST_RUN:        if (eng_done) state_d = ST_FINISH;
      ST_KI_CHECK:   state_d = (app_q == level_q) ? ST_FINISH : ST_KI_LAUNCH1;
      ST_KI_LAUNCH1: state_d = ST_KI_E1;
      ST_KI_E1:      if (eng_done) state_d = ST_KI_LAUNCH2;
      ST_KI_LAUNCH2: state_d = ST_KI_E2;
      ST_KI_E2:      if (eng_done) state_d = ST_KI_XOR;
      ST_KI_XOR:     state_d = ST_KI_LAUNCHC;
      ST_KI_LAUNCHC: state_d = ST_KI_EC;
      ST_KI_EC:      if (eng_done) state_d = ST_KI_WHI;
      ST_KI_WHI:     state_d = ST_KI_WLO;
      ST_KI_WLO:     state_d = (idx_q == LAST_PAIR) ? ST_KI_CHECK : ST_KI_LAUNCHC;
      ST_FINISH:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // outputs toward the engine and the key store
  always_comb begin
    eng_start = 1'b0;
    eng_dec   = 1'b0;
    eng_blk   = chain_q;
    tbl_wr    = '{en: 1'b0, idx: idx_q, data: chain_q[63:32]};
    key_mix   = '{en: 1'b0, k0: k0_q, k1: k1_q};
    unique case (state_q)
      ST_IDLE: begin
        eng_start = in_fire && (in_kind == KIND_ENC || in_kind == KIND_DEC);
        eng_dec   = (in_kind == KIND_DEC);
        eng_blk   = in_data_i.block_in;
        tbl_wr    = '{en: in_fire && (in_kind == KIND_WRITE),
                      idx: in_data_i.table_index, data: in_data_i.table_word};
      end
      ST_KI_LAUNCH1: begin
        eng_start = 1'b1;
        eng_blk   = {k2_q, k1_q};
      end
      ST_KI_LAUNCH2: begin
        eng_start = 1'b1;
        eng_blk   = {k1_q, k0_q};
      end
      ST_KI_LAUNCHC: eng_start = 1'b1;
      ST_KI_XOR:     key_mix.en = 1'b1;
      ST_KI_WHI:     tbl_wr.en = 1'b1;
      ST_KI_WLO:     tbl_wr = '{en: 1'b1, idx: idx_q + 11'd1, data: chain_q[31:0]};
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    game_code_d = game_code_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    k2_d        = k2_q;
    chain_d     = chain_q;
    idx_d       = idx_q;
    app_d       = app_q;
    level_d     = level_q;
    kind_d      = kind_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (cfg_valid_i) begin
      game_code_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d  = in_kind;
          res_d   = '0;
          level_d = in_data_i.key_level;
          app_d   = '0;
          if (in_kind == KIND_INIT) begin
            k0_d = game_code_q;
            k1_d = {1'b0, game_code_q[31:1]};
            k2_d = {game_code_q[30:0], 1'b0};
          end
        end
      end
      ST_RUN:      if (eng_done) res_d = eng_out;
      ST_KI_CHECK: begin
        // third application runs on a doubled k1 and halved k2
        if (app_q != level_q && app_q == 2'd2) begin
          k1_d = {k1_q[30:0], 1'b0};
          k2_d = {1'b0, k2_q[31:1]};
        end
      end
      ST_KI_E1: begin
        if (eng_done) begin
          k2_d = eng_out[63:32];
          k1_d = eng_out[31:0];
        end
      end
      ST_KI_E2: begin
        if (eng_done) begin
          k1_d = eng_out[63:32];
          k0_d = eng_out[31:0];
        end
      end
      ST_KI_XOR: begin
        chain_d = '0;
        idx_d   = '0;
      end
      ST_KI_EC:  if (eng_done) chain_d = eng_out;
      ST_KI_WLO: begin
        idx_d = idx_q + 11'd2;
        if (idx_q == LAST_PAIR) begin
          app_d = app_q + 2'd1;
        end
      end
      default: ;
    endcase

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = '{block_out: res_q, done_kind: kind_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      game_code_q <= '0;
      out_valid_q <= 1'b0;
      app_q       <= '0;
      level_q     <= '0;
      idx_q       <= '0;
      kind_q      <= KIND_WRITE;
      k0_q        <= '0;
      k1_q        <= '0;
      k2_q        <= '0;
      chain_q     <= '0;
    end else begin
      state_q     <= state_d;
      game_code_q <= game_code_d;
      out_valid_q <= out_valid_d;
      app_q       <= app_d;
      level_q     <= level_d;
      idx_q       <= idx_d;
      kind_q      <= kind_d;
      k0_q        <= k0_d;
      k1_q        <= k1_d;
      k2_q        <= k2_d;
      chain_q     <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  kbc_round_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eng_start),
    .dec_i   (eng_dec),
    .blk_i   (eng_blk),
    .rd_i    (st_rd),
    .rd_o    (eng_rd),
    .done_o  (eng_done),
    .blk_o   (eng_out)
  );

  kbc_key_store u_store (
    .clk_i (clk_i),
    .wr_i  (tbl_wr),
    .mix_i (key_mix),
    .rd_i  (eng_rd),
    .rd_o  (st_rd)
  );

  `KBC_ASSERT_NXT(a_result_loads, load_out, out_valid_q && (state_q == ST_IDLE),
                  "result beat not loaded")
  `KBC_ASSERT_NXT(a_accept_leaves_idle, in_fire, state_q != ST_IDLE,
                  "request accepted but sequencer stayed idle")
  `KBC_ASSERT_IMP(a_pair_in_range, state_q == ST_KI_WLO, idx_q <= LAST_PAIR,
                  "table refill ran past the last pair")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the Blowfish-style cipher: table loads, encrypt/decrypt, key init.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_ITEMS = 63;

  // Mirror of the key table and key code words; expected beats wait in cipher_outputs.
  class cipher_tracker;
    logic [31:0] key_words [TBL_WORDS];
    logic [31:0] code_words [3];
    logic [31:0] game_code;
    rsp_t        cipher_outputs [$];
    int unsigned checked, mismatches;
    int unsigned n_writes, n_dropped, n_enc, n_dec, n_init;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      foreach (code_words[i]) code_words[i] = '0;
      game_code = '0;
    endfunction

    function logic [31:0] box(int unsigned b, logic [7:0] a);
      return key_words[int'(BOX_BASE) + 256 * b + int'(a)];
    endfunction

    function logic [31:0] feistel(logic [31:0] z);
      logic [31:0] f;
      f = box(0, z[31:24]) + box(1, z[23:16]);
      f = f ^ box(2, z[15:8]);
      f = f + box(3, z[7:0]);
      return f;
    endfunction

    function logic [63:0] encipher(logic [63:0] v);
      logic [31:0] x, y, z;
      x = v[63:32];
      y = v[31:0];
      for (int r = 0; r < 16; r++) begin
        z = key_words[r] ^ x;
        x = y ^ feistel(z);
        y = z;
      end
      return {y ^ key_words[17], x ^ key_words[16]};
    endfunction

    function logic [63:0] decipher(logic [63:0] v);
      logic [31:0] x, y, z;
      x = v[63:32];
      y = v[31:0];
      for (int r = 17; r >= 2; r--) begin
        z = key_words[r] ^ x;
        x = y ^ feistel(z);
        y = z;
      end
      return {y ^ key_words[0], x ^ key_words[1]};
    endfunction

    function void apply_key_code();
      logic [63:0] t;
      logic [31:0] w;
      t = encipher({code_words[2], code_words[1]});
      code_words[2] = t[63:32];
      code_words[1] = t[31:0];
      t = encipher({code_words[1], code_words[0]});
      code_words[1] = t[63:32];
      code_words[0] = t[31:0];
      for (int i = 0; i < 18; i++) begin
        w = code_words[i % 2];
        key_words[i] = key_words[i] ^ {w[7:0], w[15:8], w[23:16], w[31:24]};
      end
      // refill the whole table from a chain of encryptions starting at zero
      t = '0;
      for (int i = 0; i + 1 < int'(TBL_WORDS); i += 2) begin
        t = encipher(t);
        key_words[i]     = t[63:32];
        key_words[i + 1] = t[31:0];
      end
    endfunction

    function void run_key_init(logic [1:0] level);
      code_words[0] = game_code;
      code_words[1] = game_code >> 1;
      code_words[2] = game_code << 1;
      if (level >= 2'd1) apply_key_code();
      if (level >= 2'd2) apply_key_code();
      if (level == 2'd3) begin
        code_words[1] = code_words[1] << 1;
        code_words[2] = code_words[2] >> 1;
        apply_key_code();
      end
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      e.block_out = '0;
      e.done_kind = r.req_type;
      case (r.req_type)
        KIND_WRITE: begin
          n_writes++;
          if (r.table_index < TBL_WORDS) key_words[r.table_index] = r.table_word;
          else n_dropped++;
        end
        KIND_ENC: begin
          n_enc++;
          e.block_out = encipher(r.block_in);
        end
        KIND_DEC: begin
          n_dec++;
          e.block_out = decipher(r.block_in);
        end
        default: begin
          n_init++;
          run_key_init(r.key_level);
        end
      endcase
      cipher_outputs.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (cipher_outputs.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got block_out %h done_kind %0d",
                 $time, got.block_out, got.done_kind);
        mismatches++;
        return;
      end
      e = cipher_outputs.pop_front();
      checked++;
      if (got.block_out !== e.block_out) begin
        $display("%0t: block_out expected %h got %h", $time, e.block_out, got.block_out);
        mismatches++;
      end
      if (got.done_kind !== e.done_kind) begin
        $display("%0t: done_kind expected %0d got %0d", $time, e.done_kind, got.done_kind);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  req_t        in_data_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [31:0] cfg_data_i  = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  rsp_t        out_data_o;
  logic        cfg_ready_o;

  cipher_tracker board = new();
  int unsigned   tx_gap_max  = 12;
  int unsigned   rx_gap_max  = 12;
  int unsigned   rx_hold     = 0;
  int unsigned   cycle_count = 0;
  int unsigned   n_codes     = 0;

  key1_blowfish_cipher uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d beats outstanding",
             $time, cycle_count, board.cipher_outputs.size());
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (rx_hold != 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      board.check_result(out_data_o);
      if (board.checked % 64 == 0) rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
    end
  end

  function automatic req_t random_req(kind_e k);
    req_t r;
    r.req_type    = k;
    r.table_index = 11'($urandom_range(0, 2047));
    r.table_word  = $urandom;
    r.block_in    = {$urandom, $urandom};
    r.key_level   = 2'($urandom_range(0, 3));
    return r;
  endfunction

  // valid stays up across back-to-back beats; this task only drops it when a gap is drawn
  task automatic send_request(req_t r);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    board.note_request(r);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.cipher_outputs.size() != 0);
  endtask

  task automatic write_game_code(logic [31:0] code);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    board.game_code = code;
    n_codes++;
  endtask

  task automatic send_kind(kind_e k);
    send_request(random_req(k));
  endtask

  task automatic send_block(kind_e k, logic [63:0] blk);
    req_t r;
    r = random_req(k);
    r.block_in = blk;
    send_request(r);
  endtask

  task automatic send_write(logic [10:0] idx, logic [31:0] word);
    req_t r;
    r = random_req(KIND_WRITE);
    r.table_index = idx;
    r.table_word  = word;
    send_request(r);
  endtask

  task automatic send_init(logic [1:0] level);
    req_t r;
    r = random_req(KIND_INIT);
    r.key_level = level;
    send_request(r);
  endtask

  task automatic run_phase(logic [31:0] code);
    req_t        r;
    int unsigned init_at, pick;
    settle();
    write_game_code(code);
    init_at = $urandom_range(0, PHASE_ITEMS - 1);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 50 == 0) tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      pick = $urandom_range(0, 99);
      if (n == init_at) begin
        r = random_req(KIND_INIT);
      end else if (pick < 35) begin
        r = random_req(KIND_WRITE);
        r.table_index = (pick < 30) ? 11'($urandom_range(0, TBL_WORDS - 1))
                                    : 11'($urandom_range(TBL_WORDS, 2047));
      end else if (pick < 67) begin
        r = random_req(KIND_ENC);
      end else begin
        r = random_req(KIND_DEC);
        // about half the decrypts undo a ciphertext made under the current table
        if (pick < 84) r.block_in = board.encipher(r.block_in);
      end
      send_request(r);
    end
  endtask

  initial begin : stimulus
    logic [31:0] codes [6];
    codes[0] = 32'h0000_0000;
    codes[1] = 32'hFFFF_FFFF;
    codes[2] = 32'h8000_0000;
    codes[3] = 32'h0000_0001;
    codes[4] = $urandom;
    codes[5] = $urandom;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_game_code(32'h5A3C_96E1);

    // full table load; first and last words at the extremes
    for (int i = 0; i < int'(TBL_WORDS); i++) begin
      if (i == 0) send_write(11'(i), 32'h0000_0000);
      else if (i == int'(TBL_WORDS) - 1) send_write(11'(i), 32'hFFFF_FFFF);
      else send_write(11'(i), $urandom);
    end

    // writes past the table end are dropped but still answered
    send_write(11'h7FF, 32'hFFFF_FFFF);
    send_write(TBL_WORDS, 32'hDEAD_BEEF);
    send_block(KIND_ENC, 64'h0);
    send_block(KIND_ENC, '1);
    send_block(KIND_DEC, 64'h0);
    send_block(KIND_DEC, '1);
    send_block(KIND_DEC, board.encipher(64'h0123_4567_89AB_CDEF));
    send_init(2'd0);
    send_kind(KIND_ENC);
    send_init(2'd1);
    send_kind(KIND_ENC);
    send_block(KIND_DEC, board.encipher({$urandom, $urandom}));
    send_write(11'd0, $urandom);
    send_write(TBL_WORDS - 11'd1, $urandom);
    send_kind(KIND_ENC);
    send_init(2'd2);
    send_kind(KIND_DEC);
    send_init(2'd3);
    send_kind(KIND_ENC);
    send_kind(KIND_DEC);

    // stall the result side for a long stretch while beats keep coming
    rx_hold = 400;
    tx_gap_max = 0;
    repeat (12) send_kind(($urandom_range(0, 1) == 0) ? KIND_ENC : KIND_DEC);
    settle();
    tx_gap_max = 12;

    foreach (codes[i]) run_phase(codes[i]);

    settle();
    repeat (40) @(posedge clk_i);
    $display("covered %0d table writes (%0d past the end), %0d encrypts, %0d decrypts, %0d key inits",
             board.n_writes, board.n_dropped, board.n_enc, board.n_dec, board.n_init);
    $display("%0d game code settings, %0d beats checked, %0d mismatches",
             n_codes, board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/kbc_pkg.sv
hdl/kbc_box_ram.sv
hdl/kbc_key_store.sv
hdl/kbc_round_engine.sv
hdl/key1_blowfish_cipher.sv
bench/testbench.sv
